>>> hw/rtl/lsss_pkg.sv
package lsss_pkg;

    localparam int REQ_W       = 3;
    localparam int STAT_W      = 3;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;
    localparam int CNT_W       = 5;
    localparam int OUT_TDATA_W = 48;
    localparam int MAX_RESULTS = 16;
    localparam int STEP_W      = 5;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_SEARCH = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_SORT   = 3'd3,
        REQ_READ   = 3'd4
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 3'd0,
        STAT_FOUND     = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_FULL      = 3'd4
    } t_status;

    // jump conditions
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_EMPTY,
        COND_FULL,
        COND_I_LT_FILL,
        COND_J_LT_FILL,
        COND_I1_GE_FILL,
        COND_PICK_EQ_I,
        COND_I1_LT_N
    } t_cond;

    typedef enum logic [2:0] {RD_NONE, RD_I, RD_I1, RD_J, RD_FILL} t_rd;
    typedef enum logic [1:0] {WR_NONE, WR_APPEND, WR_PICK_RD, WR_I_MIN} t_wr;
    typedef enum logic       {FILL_HOLD, FILL_DEC} t_fill_op;
    typedef enum logic [1:0] {I_HOLD, I_CLR, I_INC} t_i_op;
    typedef enum logic [1:0] {J_HOLD, J_LOAD, J_INC} t_j_op;
    typedef enum logic [1:0] {SEL_HOLD, SEL_PICK_I, SEL_MIN_RD, SEL_CMP} t_sel_op;
    typedef enum logic [1:0] {HITS_HOLD, HITS_CLR, HITS_CNT} t_hits_op;
    typedef enum logic [2:0] {
        EM_NONE,
        EM_APPEND,
        EM_FULL,
        EM_EMPTY,
        EM_SEARCH,
        EM_REMOVE,
        EM_ENTRY
    } t_emit;

    typedef struct packed {
        logic     wait_req;
        t_cond    cond;
        t_step    target;
        t_rd      rd_sel;
        t_wr      wr;
        t_fill_op fill_op;
        t_i_op    i_op;
        t_j_op    j_op;
        t_sel_op  sel_op;
        t_hits_op hits_op;
        t_emit    emit;
    } t_ctl;

    typedef struct packed {
        logic stall;
        logic empty;
        logic full;
        logic i_lt_fill;
        logic j_lt_fill;
        logic i1_ge_fill;
        logic pick_eq_i;
        logic i1_lt_n;
    } t_flags;

    // program steps
    localparam t_step S_IDLE       = 5'd0;
    localparam t_step S_APP        = 5'd1;
    localparam t_step S_APP_W      = 5'd2;
    localparam t_step S_APP_E      = 5'd3;
    localparam t_step S_APP_FULL   = 5'd4;
    localparam t_step S_EMPTY      = 5'd5;
    localparam t_step S_SRCH       = 5'd6;
    localparam t_step S_SRCH_RD    = 5'd7;
    localparam t_step S_SRCH_CMP   = 5'd8;
    localparam t_step S_SRCH_E     = 5'd9;
    localparam t_step S_REM        = 5'd10;
    localparam t_step S_REM_DEC    = 5'd11;
    localparam t_step S_REM_RD     = 5'd12;
    localparam t_step S_REM_E      = 5'd13;
    localparam t_step S_SORT       = 5'd14;
    localparam t_step S_SORT_OUT   = 5'd15;
    localparam t_step S_SORT_MIN   = 5'd16;
    localparam t_step S_SORT_SCAN  = 5'd17;
    localparam t_step S_SORT_CHK   = 5'd18;
    localparam t_step S_SORT_SWP   = 5'd19;
    localparam t_step S_SORT_PUT   = 5'd20;
    localparam t_step S_SORT_NEXT  = 5'd21;
    localparam t_step S_RO         = 5'd22;
    localparam t_step S_RO_CLR     = 5'd23;
    localparam t_step S_RO_RD      = 5'd24;
    localparam t_step S_RO_E       = 5'd25;
    localparam t_step S_RO_END     = 5'd26;

    localparam t_ctl CTL_NOP = '{
        wait_req: 1'b0,
        cond:     COND_NEVER,
        target:   S_IDLE,
        rd_sel:   RD_NONE,
        wr:       WR_NONE,
        fill_op:  FILL_HOLD,
        i_op:     I_HOLD,
        j_op:     J_HOLD,
        sel_op:   SEL_HOLD,
        hits_op:  HITS_HOLD,
        emit:     EM_NONE
    };

    // control store
    function automatic t_ctl ucode(input t_step step);
        t_ctl c;
        c = CTL_NOP;
        unique case (step)
            S_IDLE: begin
                c.wait_req = 1'b1;
            end
            S_APP: begin
                c.cond   = COND_FULL;
                c.target = S_APP_FULL;
            end
            S_APP_W: begin
                c.wr = WR_APPEND;
            end
            S_APP_E: begin
                c.emit = EM_APPEND;
                c.cond = COND_ALWAYS;
            end
            S_APP_FULL: begin
                c.emit = EM_FULL;
                c.cond = COND_ALWAYS;
            end
            S_EMPTY: begin
                c.emit = EM_EMPTY;
                c.cond = COND_ALWAYS;
            end
            S_SRCH: begin
                c.cond    = COND_EMPTY;
                c.target  = S_EMPTY;
                c.i_op    = I_CLR;
                c.hits_op = HITS_CLR;
            end
            S_SRCH_RD: begin
                c.rd_sel = RD_I;
                c.i_op   = I_INC;
            end
            S_SRCH_CMP: begin
                c.hits_op = HITS_CNT;
                c.rd_sel  = RD_I;
                c.i_op    = I_INC;
                c.cond    = COND_I_LT_FILL;
                c.target  = S_SRCH_CMP;
            end
            S_SRCH_E: begin
                c.emit = EM_SEARCH;
                c.cond = COND_ALWAYS;
            end
            S_REM: begin
                c.cond   = COND_EMPTY;
                c.target = S_EMPTY;
            end
            S_REM_DEC: begin
                c.fill_op = FILL_DEC;
            end
            S_REM_RD: begin
                c.rd_sel = RD_FILL;
            end
            S_REM_E: begin
                c.emit = EM_REMOVE;
                c.cond = COND_ALWAYS;
            end
            S_SORT: begin
                c.cond   = COND_EMPTY;
                c.target = S_EMPTY;
                c.i_op   = I_CLR;
            end
            S_SORT_OUT: begin
                c.cond   = COND_I1_GE_FILL;
                c.target = S_RO_CLR;
                c.rd_sel = RD_I;
                c.sel_op = SEL_PICK_I;
                c.j_op   = J_LOAD;
            end
            S_SORT_MIN: begin
                c.sel_op = SEL_MIN_RD;
                c.rd_sel = RD_J;
                c.j_op   = J_INC;
            end
            S_SORT_SCAN: begin
                c.sel_op = SEL_CMP;
                c.rd_sel = RD_J;
                c.j_op   = J_INC;
                c.cond   = COND_J_LT_FILL;
                c.target = S_SORT_SCAN;
            end
            S_SORT_CHK: begin
                c.rd_sel = RD_I;
                c.cond   = COND_PICK_EQ_I;
                c.target = S_SORT_NEXT;
            end
            S_SORT_SWP: begin
                c.wr = WR_PICK_RD;
            end
            S_SORT_PUT: begin
                c.wr     = WR_I_MIN;
                c.i_op   = I_INC;
                c.cond   = COND_ALWAYS;
                c.target = S_SORT_OUT;
            end
            S_SORT_NEXT: begin
                c.i_op   = I_INC;
                c.cond   = COND_ALWAYS;
                c.target = S_SORT_OUT;
            end
            S_RO: begin
                c.cond   = COND_EMPTY;
                c.target = S_EMPTY;
            end
            S_RO_CLR: begin
                c.i_op = I_CLR;
            end
            S_RO_RD: begin
                c.rd_sel = RD_I;
            end
            S_RO_E: begin
                c.emit   = EM_ENTRY;
                c.rd_sel = RD_I1;
                c.i_op   = I_INC;
                c.cond   = COND_I1_LT_N;
                c.target = S_RO_E;
            end
            S_RO_END: begin
                c.cond = COND_ALWAYS;
            end
            default: begin
                c.cond = COND_ALWAYS;
            end
        endcase
        return c;
    endfunction

    // entry step of each request; unknown codes are dropped
    function automatic t_step dispatch(input logic [REQ_W-1:0] req);
        t_step s;
        unique case (req)
            REQ_APPEND: s = S_APP;
            REQ_SEARCH: s = S_SRCH;
            REQ_REMOVE: s = S_REM;
            REQ_SORT:   s = S_SORT;
            REQ_READ:   s = S_RO;
            default:    s = S_IDLE;
        endcase
        return s;
    endfunction

endpackage

>>> hw/rtl/lsss_seq.sv
module lsss_seq
    import lsss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [REQ_W-1:0] i_req,
    input  t_flags           i_flags,
    output t_ctl             o_ctl,
    output logic             o_in_ready
);

    t_step r_step;
    t_step n_step;
    t_ctl  w_ctl;
    logic  w_jump;

    assign w_ctl      = ucode(r_step);
    assign o_ctl      = w_ctl;
    assign o_in_ready = w_ctl.wait_req;

    always_comb begin
        unique case (w_ctl.cond)
            COND_NEVER:      w_jump = 1'b0;
            COND_ALWAYS:     w_jump = 1'b1;
            COND_EMPTY:      w_jump = i_flags.empty;
            COND_FULL:       w_jump = i_flags.full;
            COND_I_LT_FILL:  w_jump = i_flags.i_lt_fill;
            COND_J_LT_FILL:  w_jump = i_flags.j_lt_fill;
            COND_I1_GE_FILL: w_jump = i_flags.i1_ge_fill;
            COND_PICK_EQ_I:  w_jump = i_flags.pick_eq_i;
            COND_I1_LT_N:    w_jump = i_flags.i1_lt_n;
            default:         w_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (w_ctl.wait_req) begin
            n_step = i_in_valid ? dispatch(i_req) : r_step;
        end else if (i_flags.stall) begin
            // hold while the result register is occupied
            n_step = r_step;
        end else if (w_jump) begin
            n_step = w_ctl.target;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> hw/rtl/lsss_dp.sv
module lsss_dp
    import lsss_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    input  logic                  i_accept,
    input  logic [IN_DATA_W-1:0]  i_value,
    output t_flags                o_flags,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output t_status               o_m_status,
    output logic [OUT_DATA_W-1:0] o_m_data,
    output logic [CNT_W-1:0]      o_m_match,
    output logic [CNT_W-1:0]      o_m_count,
    output logic                  o_m_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic [DATA_WIDTH-1:0] r_key;
    logic [DATA_WIDTH-1:0] r_rd;
    logic [DATA_WIDTH-1:0] r_min;
    logic [FW-1:0]         r_fill;
    logic [FW-1:0]         r_i;
    logic [FW-1:0]         r_j;
    logic [FW-1:0]         r_hits;
    logic [AW-1:0]         r_pick;

    logic                  r_m_valid;
    t_status               r_m_status;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [CNT_W-1:0]      r_m_match;
    logic [CNT_W-1:0]      r_m_count;
    logic                  r_m_last;

    t_status               n_m_status;
    logic [OUT_DATA_W-1:0] n_m_data;
    logic [CNT_W-1:0]      n_m_match;
    logic                  n_m_last;

    logic                  w_stall;
    logic                  w_go;
    logic [FW:0]           w_i1;
    logic [FW-1:0]         w_n;
    logic [AW-1:0]         w_rd_addr;
    logic [OUT_DATA_W-1:0] w_key_out;
    logic [OUT_DATA_W-1:0] w_rd_out;

    assign w_stall = (i_ctl.emit != EM_NONE) && r_m_valid && !i_m_ready;
    assign w_go    = !w_stall;
    assign w_i1    = {1'b0, r_i} + 1'b1;
    // read-out stops after the first MAX_RESULTS entries
    assign w_n     = (int'(r_fill) > MAX_RESULTS) ? FW'(MAX_RESULTS) : r_fill;

    assign w_key_out = OUT_DATA_W'(signed'(r_key));
    assign w_rd_out  = OUT_DATA_W'(signed'(r_rd));

    assign o_flags.stall      = w_stall;
    assign o_flags.empty      = (r_fill == '0);
    assign o_flags.full       = (r_fill == FW'(DEPTH));
    assign o_flags.i_lt_fill  = (r_i < r_fill);
    assign o_flags.j_lt_fill  = (r_j < r_fill);
    assign o_flags.i1_ge_fill = (w_i1 >= {1'b0, r_fill});
    assign o_flags.pick_eq_i  = (FW'(r_pick) == r_i);
    assign o_flags.i1_lt_n    = (w_i1 < {1'b0, w_n});

    always_comb begin
        case (i_ctl.rd_sel)
            RD_I:    w_rd_addr = r_i[AW-1:0];
            RD_I1:   w_rd_addr = w_i1[AW-1:0];
            RD_J:    w_rd_addr = r_j[AW-1:0];
            RD_FILL: w_rd_addr = r_fill[AW-1:0];
            default: w_rd_addr = r_i[AW-1:0];
        endcase
    end

    // entry store: one write and one registered read per cycle while not stalled
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            case (i_ctl.wr)
                WR_APPEND:  r_mem[r_fill[AW-1:0]] <= r_key;
                WR_PICK_RD: r_mem[r_pick]         <= r_rd;
                WR_I_MIN:   r_mem[r_i[AW-1:0]]    <= r_min;
                default:    ;
            endcase
            if (i_ctl.rd_sel != RD_NONE) begin
                r_rd <= r_mem[w_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_go) begin
            if (i_ctl.wr == WR_APPEND) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_ctl.fill_op == FILL_DEC) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_key <= DATA_WIDTH'(signed'(i_value));
        end
        if (w_go) begin
            case (i_ctl.i_op)
                I_CLR:   r_i <= '0;
                I_INC:   r_i <= r_i + 1'b1;
                default: ;
            endcase
            case (i_ctl.j_op)
                J_LOAD:  r_j <= FW'(w_i1);
                J_INC:   r_j <= r_j + 1'b1;
                default: ;
            endcase
            case (i_ctl.hits_op)
                HITS_CLR: r_hits <= '0;
                HITS_CNT: r_hits <= r_hits + FW'(r_rd == r_key);
                default:  ;
            endcase
            case (i_ctl.sel_op)
                SEL_PICK_I: r_pick <= AW'(r_i);
                SEL_MIN_RD: r_min  <= r_rd;
                SEL_CMP: begin
                    // strict less-than keeps the first minimum
                    if ($signed(r_rd) < $signed(r_min)) begin
                        r_min  <= r_rd;
                        r_pick <= AW'(r_j - 1'b1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_m_status = STAT_DONE;
        n_m_data   = '0;
        n_m_match  = '0;
        n_m_last   = 1'b1;
        case (i_ctl.emit)
            EM_APPEND: begin
                n_m_data = w_key_out;
            end
            EM_FULL: begin
                n_m_status = STAT_FULL;
                n_m_data   = w_key_out;
            end
            EM_EMPTY: begin
                n_m_status = STAT_EMPTY;
            end
            EM_SEARCH: begin
                n_m_status = (r_hits != '0) ? STAT_FOUND : STAT_NOT_FOUND;
                n_m_data   = w_key_out;
                n_m_match  = CNT_W'(r_hits);
            end
            EM_REMOVE: begin
                n_m_data = w_rd_out;
            end
            EM_ENTRY: begin
                n_m_data = w_rd_out;
                n_m_last = (w_i1 == {1'b0, w_n});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((i_ctl.emit != EM_NONE) && w_go) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_ctl.emit != EM_NONE) && w_go) begin
            r_m_status <= n_m_status;
            r_m_data   <= n_m_data;
            r_m_match  <= n_m_match;
            r_m_count  <= (i_ctl.emit == EM_EMPTY) ? '0 : CNT_W'(r_fill);
            r_m_last   <= n_m_last;
        end
    end

    assign o_m_valid  = r_m_valid;
    assign o_m_status = r_m_status;
    assign o_m_data   = r_m_data;
    assign o_m_match  = r_m_match;
    assign o_m_count  = r_m_count;
    assign o_m_last   = r_m_last;

endmodule

>>> hw/rtl/list_store_search_sort.sv
// channel   dir  handshake                      payload
// request   in   s_axis_tvalid / s_axis_tready  tdata: value; tuser: req_type
// result    out  m_axis_tvalid / m_axis_tready  tdata: data_word, match_count,
//                                               entry_count; tuser: status; tlast
//
// A microprogram steps once per cycle unless stalled; the store has one port, one read per step.
// Read-out returns the first n = min(fill, 16) entries; sort reorders the store and then
// reads it out; search, remove, sort and read on an empty store give an EMPTY status.
// Requests are taken only between programs; a result not yet taken stalls the program when it next emits.
// Reset (synchronous, active low) empties the store; no clearing pass is needed.
module list_store_search_sort
    import lsss_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // [31:0] value
    input  logic [REQ_W-1:0]       s_axis_tuser,   // [2:0] req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] data_word, [36:32] match_count,
                                                   // [41:37] entry_count, rest zero
    output logic [STAT_W-1:0]      m_axis_tuser,   // [2:0] status
    output logic                   m_axis_tlast
);

    t_ctl                  w_ctl;
    t_flags                w_flags;
    logic                  w_in_ready;
    t_status               w_status;
    logic [OUT_DATA_W-1:0] w_data;
    logic [CNT_W-1:0]      w_match;
    logic [CNT_W-1:0]      w_count;

    lsss_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req      (s_axis_tuser),
        .i_flags    (w_flags),
        .o_ctl      (w_ctl),
        .o_in_ready (w_in_ready)
    );

    lsss_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_accept   (s_axis_tvalid && w_in_ready),
        .i_value    (s_axis_tdata),
        .o_flags    (w_flags),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_status (w_status),
        .o_m_data   (w_data),
        .o_m_match  (w_match),
        .o_m_count  (w_count),
        .o_m_last   (m_axis_tlast)
    );

    assign s_axis_tready = w_in_ready;
    assign m_axis_tuser  = w_status;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_DATA_W - 2*CNT_W){1'b0}},
                            w_count, w_match, w_data};

endmodule

>>> sim/tb_list_store_search_sort.sv
`default_nettype none

module tb_list_store_search_sort;
    import lsss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 16;
    localparam int TARGET_REQS = 300;
    localparam int CALM_REQS   = 260;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_OFF    = 400;
    localparam int MAX_REPORTS = 30;
    localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;

    typedef struct {
        t_status               status;
        logic [OUT_DATA_W-1:0] word;
        logic [CNT_W-1:0]      hits_cnt;
        logic [CNT_W-1:0]      count;
        logic                  last;
    } t_list_result;

    class list_scoreboard;
        logic [OUT_DATA_W-1:0] store [STORE_DEPTH];
        int fill;
        int errors;
        int n_checked;
        int n_sorts;
        int n_full;
        int n_empty;
        t_list_result awaited_q[$];

        function void push_result(t_status st, logic [OUT_DATA_W-1:0] w, int hits, bit l);
            t_list_result r;
            r.status   = st;
            r.word     = w;
            r.hits_cnt = CNT_W'(hits);
            r.count    = CNT_W'(fill);
            r.last     = l;
            awaited_q.push_back(r);
        endfunction

        // selection sort, first minimum wins, signed compare
        function void order_ascending();
            int pick;
            logic [OUT_DATA_W-1:0] t;
            for (int i = 0; i + 1 < fill; i++) begin
                pick = i;
                for (int j = i + 1; j < fill; j++) begin
                    if ($signed(store[pick]) > $signed(store[j])) begin
                        pick = j;
                    end
                end
                if (pick != i) begin
                    t           = store[pick];
                    store[pick] = store[i];
                    store[i]    = t;
                end
            end
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [IN_DATA_W-1:0] val);
            int hits;
            int n;
            if (req > REQ_READ) begin
                return;
            end
            if (req == REQ_APPEND) begin
                if (fill >= STORE_DEPTH) begin
                    n_full++;
                    push_result(STAT_FULL, val, 0, 1'b1);
                end else begin
                    store[fill] = val;
                    fill++;
                    push_result(STAT_DONE, val, 0, 1'b1);
                end
                return;
            end
            if (fill == 0) begin
                n_empty++;
                push_result(STAT_EMPTY, '0, 0, 1'b1);
                return;
            end
            case (req)
                REQ_SEARCH: begin
                    hits = 0;
                    for (int i = 0; i < fill; i++) begin
                        if (store[i] == val) begin
                            hits++;
                        end
                    end
                    push_result(hits != 0 ? STAT_FOUND : STAT_NOT_FOUND, val, hits, 1'b1);
                end
                REQ_REMOVE: begin
                    fill--;
                    push_result(STAT_DONE, store[fill], 0, 1'b1);
                end
                default: begin
                    if (req == REQ_SORT) begin
                        n_sorts++;
                        order_ascending();
                    end
                    n = fill < MAX_RESULTS ? fill : MAX_RESULTS;
                    for (int i = 0; i < n; i++) begin
                        push_result(STAT_DONE, store[i], 0, i + 1 == n);
                    end
                end
            endcase
        endfunction

        function void mismatch(string field, logic [OUT_DATA_W-1:0] e, logic [OUT_DATA_W-1:0] a);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, e, a);
            end
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [OUT_TDATA_W-1:0] td, logic l);
            t_list_result e;
            n_checked++;
            if (awaited_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: unexpected word: expected none, actual status %0d data %h",
                             $time, st, td[OUT_DATA_W-1:0]);
                end
                return;
            end
            e = awaited_q.pop_front();
            if (st !== e.status) begin
                mismatch("status", OUT_DATA_W'(e.status), OUT_DATA_W'(st));
            end
            if (td[OUT_DATA_W-1:0] !== e.word) begin
                mismatch("data_word", e.word, td[OUT_DATA_W-1:0]);
            end
            if (td[OUT_DATA_W +: CNT_W] !== e.hits_cnt) begin
                mismatch("match_count", OUT_DATA_W'(e.hits_cnt),
                         OUT_DATA_W'(td[OUT_DATA_W +: CNT_W]));
            end
            if (td[OUT_DATA_W+CNT_W +: CNT_W] !== e.count) begin
                mismatch("entry_count", OUT_DATA_W'(e.count),
                         OUT_DATA_W'(td[OUT_DATA_W+CNT_W +: CNT_W]));
            end
            if (l !== e.last) begin
                mismatch("last", OUT_DATA_W'(e.last), OUT_DATA_W'(l));
            end
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;   // [31:0] value
    logic [REQ_W-1:0]       s_axis_tuser;   // [2:0] req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] data_word, [36:32] match_count,
                                            // [41:37] entry_count
    logic [STAT_W-1:0]      m_axis_tuser;   // [2:0] status
    logic                   m_axis_tlast;

    list_scoreboard sb = new;
    int  n_reqs   = 0;
    int  cycles   = 0;
    bit  gappy    = 1'b0;
    bit  calm     = 1'b0;
    bit  held_off = 1'b0;

    list_store_search_sort dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // check results before noting the request taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(s_axis_tuser, s_axis_tdata);
            end
        end
    end

    // result side: random stalls, one long hold-off to back the block up
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && n_reqs >= 60) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_OFF) @(negedge i_clk);
                held_off      = 1'b1;
                m_axis_tready = 1'b1;
            end else if (gappy && !calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] rand_word();
        int v;
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3: begin
                v = $urandom_range(0, 8);
                return IN_DATA_W'(v - 4);
            end
            default: return $urandom();
        endcase
    endfunction

    // call at a falling edge; returns on a falling edge after the take and any gap
    task automatic offer(input logic [REQ_W-1:0] req, input logic [IN_DATA_W-1:0] val);
        s_axis_tuser  = req;
        s_axis_tdata  = val;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (req <= REQ_READ) begin
            n_reqs++;
        end
        calm = n_reqs >= CALM_REQS;
        if (gappy && !calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
    endtask

    task automatic mixed_item();
        int roll;
        logic [IN_DATA_W-1:0] key;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            offer(REQ_APPEND, rand_word());
        end else if (roll < 60) begin
            key = rand_word();
            if (sb.fill > 0 && $urandom_range(0, 2) != 0) begin
                key = sb.store[$urandom_range(0, sb.fill - 1)];
            end
            offer(REQ_SEARCH, key);
        end else if (roll < 75) begin
            offer(REQ_REMOVE, $urandom());
        end else if (roll < 82) begin
            offer(REQ_SORT, $urandom());
        end else if (roll < 92) begin
            offer(REQ_READ, $urandom());
        end else begin
            offer(REQ_W'(REQ_UNUSED_FIRST + $urandom_range(0, 2)), $urandom());
        end
    endtask

    initial begin
        bit first;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty store, unused codes, extremes, duplicates, sole entry
        offer(REQ_SEARCH, 32'd0);
        offer(REQ_REMOVE, $urandom());
        offer(REQ_SORT, $urandom());
        offer(REQ_READ, $urandom());
        offer(REQ_UNUSED_FIRST, $urandom());
        offer(REQ_W'(REQ_UNUSED_FIRST + 1), $urandom());
        offer(REQ_W'(REQ_UNUSED_FIRST + 2), $urandom());
        offer(REQ_APPEND, 32'h7fff_ffff);
        offer(REQ_APPEND, 32'h8000_0000);
        offer(REQ_APPEND, 32'hffff_ffff);
        offer(REQ_APPEND, 32'h0000_0000);
        offer(REQ_APPEND, 32'h7fff_ffff);
        offer(REQ_SEARCH, 32'h7fff_ffff);
        offer(REQ_SEARCH, 32'h0000_0001);
        offer(REQ_READ, $urandom());
        offer(REQ_SORT, $urandom());
        offer(REQ_SEARCH, 32'h8000_0000);
        offer(REQ_REMOVE, $urandom());
        offer(REQ_REMOVE, $urandom());
        offer(REQ_REMOVE, $urandom());
        offer(REQ_SORT, $urandom());
        offer(REQ_REMOVE, $urandom());
        offer(REQ_READ, $urandom());
        offer(REQ_APPEND, 32'd5);
        offer(REQ_SORT, $urandom());

        first = 1'b1;
        while (n_reqs < TARGET_REQS) begin
            gappy = $urandom_range(0, 2) != 0;
            case (first ? 0 : $urandom_range(0, 9))
                0, 1: begin
                    // fill to the brim, then overflow
                    while (sb.fill < STORE_DEPTH) offer(REQ_APPEND, rand_word());
                    repeat ($urandom_range(1, 2)) offer(REQ_APPEND, rand_word());
                    if ($urandom_range(0, 1) == 0) begin
                        offer(REQ_SORT, $urandom());
                    end
                end
                2: begin
                    // drain to empty, then poke the empty store
                    while (sb.fill > 0) offer(REQ_REMOVE, $urandom());
                    offer(REQ_REMOVE, $urandom());
                    offer(REQ_SEARCH, rand_word());
                end
                3: begin
                    offer($urandom_range(0, 1) ? REQ_SORT : REQ_READ, $urandom());
                end
                default: begin
                    repeat ($urandom_range(4, 8)) mixed_item();
                end
            endcase
            first = 1'b0;
        end
        s_axis_tvalid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("%0d requests: %0d sorts, %0d overflowing appends, %0d on an empty store",
                 n_reqs, sb.n_sorts, sb.n_full, sb.n_empty);
        $display("%0d result words checked, receiver hold-off of %0d cycles applied",
                 sb.n_checked, HOLD_OFF);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
